@@ sv/rau_pkg.sv @@
package rau_pkg;

  // Range accepted by the overflow check; the ports stay 32 bits wide.
  localparam int WORD_BITS = 32;

  localparam int FIELD_W    = 32;
  localparam int DEN_W      = 31;
  localparam int MAG_W      = 64;
  localparam int MUL_W      = 32;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 4 * FIELD_W;
  localparam int OUT_DATA_W = 96;
  localparam int DIV_STEPS  = MAG_W;
  localparam int SHIFT_W    = $clog2(MAG_W);
  localparam int VAL_N      = 16;

  localparam logic [MAG_W:0] WORD_LIM =
    ({{MAG_W{1'b0}}, 1'b1} << (WORD_BITS - 1)) - {{MAG_W{1'b0}}, 1'b1};

  // Operation codes
  localparam logic [CMD_W-1:0] CMD_NORM  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EQ    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LESS  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_WHOLE = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd7;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  // Datapath value selects
  typedef logic [3:0] val_sel_t;
  localparam val_sel_t V_AN   = 4'd0;
  localparam val_sel_t V_AD   = 4'd1;
  localparam val_sel_t V_BN   = 4'd2;
  localparam val_sel_t V_BD   = 4'd3;
  localparam val_sel_t V_RN   = 4'd4;
  localparam val_sel_t V_RD   = 4'd5;
  localparam val_sel_t V_T1   = 4'd6;
  localparam val_sel_t V_T2   = 4'd7;
  localparam val_sel_t V_GCD  = 4'd8;
  localparam val_sel_t V_QUO  = 4'd9;
  localparam val_sel_t V_REM  = 4'd10;
  localparam val_sel_t V_PROD = 4'd11;
  localparam val_sel_t V_ONE  = 4'd12;
  localparam val_sel_t V_SUM  = 4'd13;

  // Datapath register write targets
  typedef logic [3:0] dst_t;
  localparam dst_t D_NONE = 4'd0;
  localparam dst_t D_AN   = 4'd1;
  localparam dst_t D_AD   = 4'd2;
  localparam dst_t D_BN   = 4'd3;
  localparam dst_t D_BD   = 4'd4;
  localparam dst_t D_RN   = 4'd5;
  localparam dst_t D_RD   = 4'd6;
  localparam dst_t D_T1   = 4'd7;
  localparam dst_t D_T2   = 4'd8;
  localparam dst_t D_WM   = 4'd9;

  // Sign flag updates
  typedef logic [3:0] sgn_t;
  localparam sgn_t SG_NONE  = 4'd0;
  localparam sgn_t SG_R_A   = 4'd1;
  localparam sgn_t SG_R_B   = 4'd2;
  localparam sgn_t SG_A_R   = 4'd3;
  localparam sgn_t SG_B_R   = 4'd4;
  localparam sgn_t SG_R_XOR = 4'd5;
  localparam sgn_t SG_R_CLR = 4'd6;
  localparam sgn_t SG_W_A   = 4'd7;
  localparam sgn_t SG_R_SUM = 4'd8;

  // Kind of result formed at the end of an item
  typedef logic [2:0] kind_t;
  localparam kind_t K_ZERO = 3'd0;
  localparam kind_t K_ERR  = 3'd1;
  localparam kind_t K_EQ   = 3'd2;
  localparam kind_t K_LESS = 3'd3;
  localparam kind_t K_VAL  = 3'd4;

  typedef struct packed {
    logic     load;
    logic     gcd_start;
    logic     div_start;
    logic     mul_en;
    val_sel_t opa;
    val_sel_t opb;
    dst_t     dst;
    val_sel_t wsrc;
    sgn_t     sgn;
    logic     fin;
    kind_t    kind;
  } dp_cmd_t;

  typedef struct packed {
    logic gcd_busy;
    logic div_busy;
    logic out_busy;
    logic ad_zero;
    logic bd_zero;
    logic bn_zero;
    logic rn_zero;
  } dp_stat_t;

endpackage

@@ sv/rau_gcd.sv @@
module rau_gcd (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [rau_pkg::MAG_W-1:0] x_in,
  input  logic [rau_pkg::MAG_W-1:0] y_in,
  output logic                     busy,
  output logic [rau_pkg::MAG_W-1:0] g
);
  import rau_pkg::*;

  logic [MAG_W-1:0]   x;
  logic [MAG_W-1:0]   y;
  logic [SHIFT_W-1:0] k;
  logic               finish;

  // Binary gcd, one step per cycle; common factors of two are counted in k.
  assign finish = (x == '0) || (y == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && finish) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x_in;
      y <= y_in;
      k <= '0;
    end else if (busy) begin
      if (finish) begin
        g <= (x | y) << k;
      end else if (!x[0] && !y[0]) begin
        x <= x >> 1;
        y <= y >> 1;
        k <= k + 1'b1;
      end else if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x >= y) begin
        x <= (x - y) >> 1;
      end else begin
        y <= (y - x) >> 1;
      end
    end
  end

endmodule

@@ sv/rau_div.sv @@
module rau_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [rau_pkg::MAG_W-1:0] dividend,
  input  logic [rau_pkg::MAG_W-1:0] divisor,
  output logic                     busy,
  output logic [rau_pkg::MAG_W-1:0] quo,
  output logic [rau_pkg::MAG_W-1:0] rem
);
  import rau_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [MAG_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W:0]   sh;
  logic [MAG_W:0]   diff;
  logic             take;

  // Restoring division, one quotient bit per cycle.
  assign sh   = {rem, quo[MAG_W-1]};
  assign diff = sh - {1'b0, d};
  assign take = sh >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= cnt != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      d   <= divisor;
    end else if (busy) begin
      rem <= take ? diff[MAG_W-1:0] : sh[MAG_W-1:0];
      quo <= {quo[MAG_W-2:0], take};
    end
  end

endmodule

@@ sv/rau_dp.sv @@
module rau_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  rau_pkg::dp_cmd_t              cmd,
  output rau_pkg::dp_stat_t             stat,
  input  logic [rau_pkg::IN_DATA_W-1:0]  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rau_pkg::OUT_DATA_W-1:0] out_data,
  output logic [rau_pkg::STATUS_W-1:0]   out_user
);
  import rau_pkg::*;

  logic [MAG_W-1:0] an, ad, bn, bd, rn, rd, t1, t2, wm, prod;
  logic             sa, sb, rneg, wneg;
  logic [MAG_W-1:0] vals [VAL_N];
  logic [MAG_W-1:0] opa_v, opb_v, wval;
  logic [MAG_W-1:0] gcd_v, quo_v, rem_v;
  logic             gcd_busy, div_busy;
  logic [MAG_W-1:0] sum_mag;
  logic             sum_neg;
  logic             ln, rgt, t_eq, t_lt;
  logic             wn, fit_all;

  logic [FIELD_W-1:0]  res_num, whole;
  logic [DEN_W-1:0]    res_den;
  logic                truth;
  logic [STATUS_W-1:0] status;

  function automatic logic [MAG_W-1:0] mag_of(input logic [FIELD_W-1:0] v);
    logic [FIELD_W:0] m;
    m = v[FIELD_W-1] ? ({1'b1, {FIELD_W{1'b0}}} - {1'b0, v}) : {1'b0, v};
    return MAG_W'(m);
  endfunction

  function automatic logic fits(input logic neg, input logic [MAG_W-1:0] mag);
    return {1'b0, mag} <= (WORD_LIM + {{MAG_W{1'b0}}, neg});
  endfunction

  function automatic logic [FIELD_W-1:0] to_word(input logic neg,
                                                 input logic [MAG_W-1:0] mag);
    return neg ? (~mag[FIELD_W-1:0] + 1'b1) : mag[FIELD_W-1:0];
  endfunction

  rau_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.gcd_start),
    .x_in  (opa_v),
    .y_in  (opb_v),
    .busy  (gcd_busy),
    .g     (gcd_v)
  );

  rau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (opa_v),
    .divisor  (opb_v),
    .busy     (div_busy),
    .quo      (quo_v),
    .rem      (rem_v)
  );

  // Signed sum of a*fa (t1) and b*fb (product) in sign and magnitude.
  always_comb begin
    if (sa == sb) begin
      sum_mag = t1 + prod;
      sum_neg = sa;
    end else if (t1 >= prod) begin
      sum_mag = t1 - prod;
      sum_neg = sa;
    end else begin
      sum_mag = prod - t1;
      sum_neg = sb;
    end
  end

  always_comb begin
    for (int i = 0; i < VAL_N; i++) begin
      vals[i] = '0;
    end
    vals[V_AN]   = an;
    vals[V_AD]   = ad;
    vals[V_BN]   = bn;
    vals[V_BD]   = bd;
    vals[V_RN]   = rn;
    vals[V_RD]   = rd;
    vals[V_T1]   = t1;
    vals[V_T2]   = t2;
    vals[V_GCD]  = gcd_v;
    vals[V_QUO]  = quo_v;
    vals[V_REM]  = rem_v;
    vals[V_PROD] = prod;
    vals[V_ONE]  = MAG_W'(1);
    vals[V_SUM]  = sum_mag;
  end

  assign opa_v = vals[cmd.opa];
  assign opb_v = vals[cmd.opb];
  assign wval  = vals[cmd.wsrc];

  assign stat.gcd_busy = gcd_busy;
  assign stat.div_busy = div_busy;
  assign stat.out_busy = out_valid && !out_ready;
  assign stat.ad_zero  = ad == '0;
  assign stat.bd_zero  = bd == '0;
  assign stat.bn_zero  = bn == '0;
  assign stat.rn_zero  = rn == '0;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= MAG_W'(opa_v[MUL_W-1:0]) * MAG_W'(opb_v[MUL_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      an   <= mag_of(in_data[FIELD_W-1:0]);
      ad   <= mag_of(in_data[2*FIELD_W-1:FIELD_W]);
      bn   <= mag_of(in_data[3*FIELD_W-1:2*FIELD_W]);
      bd   <= mag_of(in_data[4*FIELD_W-1:3*FIELD_W]);
      sa   <= in_data[FIELD_W-1] ^ in_data[2*FIELD_W-1];
      sb   <= in_data[3*FIELD_W-1] ^ in_data[4*FIELD_W-1];
      wm   <= '0;
      wneg <= 1'b0;
    end else begin
      unique case (cmd.dst)
        D_NONE: ;
        D_AN:   an <= wval;
        D_AD:   ad <= wval;
        D_BN:   bn <= wval;
        D_BD:   bd <= wval;
        D_RN:   rn <= wval;
        D_RD:   rd <= wval;
        D_T1:   t1 <= wval;
        D_T2:   t2 <= wval;
        D_WM:   wm <= wval;
        default: ;
      endcase
      unique case (cmd.sgn)
        SG_NONE:  ;
        SG_R_A:   rneg <= sa;
        SG_R_B:   rneg <= sb;
        SG_A_R:   sa   <= rneg;
        SG_B_R:   sb   <= rneg;
        SG_R_XOR: rneg <= sa ^ sb;
        SG_R_CLR: rneg <= 1'b0;
        SG_W_A:   wneg <= sa;
        SG_R_SUM: rneg <= sum_neg;
        default: ;
      endcase
    end
  end

  // Comparison of the cross products held in rn (left) and rd (right).
  assign ln   = sa && (rn != '0);
  assign rgt  = sb && (rd != '0);
  assign t_eq = (ln == rgt) && (rn == rd);
  assign t_lt = (ln != rgt) ? ln : (ln ? (rn > rd) : (rn < rd));

  assign wn      = wneg && (wm != '0);
  assign fit_all = fits(rneg, rn) && fits(1'b0, rd) && fits(wn, wm);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_num <= '0;
      res_den <= '0;
      whole   <= '0;
      truth   <= 1'b0;
      status  <= ST_OK;
      unique case (cmd.kind)
        K_ZERO: ;
        K_ERR:  status <= ST_ZERO_DEN;
        K_EQ:   truth  <= t_eq;
        K_LESS: truth  <= t_lt;
        K_VAL: begin
          if (fit_all) begin
            res_num <= to_word(rneg, rn);
            res_den <= rd[DEN_W-1:0];
            whole   <= to_word(wn, wm);
          end else begin
            status <= ST_OVERFLOW;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_data = {truth, whole, res_den, res_num};
  assign out_user = status;

endmodule

@@ sv/rau_ctrl.sv @@
module rau_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rau_pkg::CMD_W-1:0]   in_cmd,
  output rau_pkg::dp_cmd_t            cmd,
  input  rau_pkg::dp_stat_t           stat
);
  import rau_pkg::*;

  localparam int SW = 5;
  localparam logic [SW-1:0] S_IDLE  = 5'd0;
  localparam logic [SW-1:0] S_CHECK = 5'd1;
  localparam logic [SW-1:0] S_MA1   = 5'd2;
  localparam logic [SW-1:0] S_MA2   = 5'd3;
  localparam logic [SW-1:0] S_SA1   = 5'd4;
  localparam logic [SW-1:0] S_SA2   = 5'd5;
  localparam logic [SW-1:0] S_MB1   = 5'd6;
  localparam logic [SW-1:0] S_MB2   = 5'd7;
  localparam logic [SW-1:0] S_SB1   = 5'd8;
  localparam logic [SW-1:0] S_SB2   = 5'd9;
  localparam logic [SW-1:0] S_OP    = 5'd10;
  localparam logic [SW-1:0] S_N0    = 5'd11;
  localparam logic [SW-1:0] S_N1    = 5'd12;
  localparam logic [SW-1:0] S_N2    = 5'd13;
  localparam logic [SW-1:0] S_N3    = 5'd14;
  localparam logic [SW-1:0] S_AD1   = 5'd15;
  localparam logic [SW-1:0] S_AD2   = 5'd16;
  localparam logic [SW-1:0] S_AD3   = 5'd17;
  localparam logic [SW-1:0] S_AD4   = 5'd18;
  localparam logic [SW-1:0] S_AD5   = 5'd19;
  localparam logic [SW-1:0] S_AD6   = 5'd20;
  localparam logic [SW-1:0] S_AD7   = 5'd21;
  localparam logic [SW-1:0] S_ML1   = 5'd22;
  localparam logic [SW-1:0] S_ML2   = 5'd23;
  localparam logic [SW-1:0] S_ML3   = 5'd24;
  localparam logic [SW-1:0] S_EX1   = 5'd25;
  localparam logic [SW-1:0] S_EX2   = 5'd26;
  localparam logic [SW-1:0] S_EX3   = 5'd27;
  localparam logic [SW-1:0] S_EX4   = 5'd28;
  localparam logic [SW-1:0] S_FIN   = 5'd29;

  logic [SW-1:0]    state, state_next;
  logic [SW-1:0]    ret, ret_next;
  logic [CMD_W-1:0] op, op_next;
  logic             err, err_next;
  logic             uses_b, is_cmp;

  assign uses_b   = op inside {[CMD_ADD:CMD_LESS]};
  assign is_cmp   = op inside {CMD_EQ, CMD_LESS};
  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    ret_next   = ret;
    op_next    = op;
    err_next   = err;
    cmd        = '0;
    cmd.opa    = V_AN;
    cmd.opb    = V_AN;
    cmd.dst    = D_NONE;
    cmd.wsrc   = V_AN;
    cmd.sgn    = SG_NONE;
    cmd.kind   = K_ZERO;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          op_next    = in_cmd;
          err_next   = 1'b0;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (op == CMD_NONE) begin
          state_next = S_FIN;
        end else if (stat.ad_zero || (uses_b && stat.bd_zero) ||
                     (op == CMD_DIV && stat.bn_zero)) begin
          err_next   = 1'b1;
          state_next = S_FIN;
        end else begin
          state_next = S_MA1;
        end
      end
      S_MA1: begin
        cmd.dst = D_RN; cmd.wsrc = V_AN; cmd.sgn = SG_R_A;
        state_next = S_MA2;
      end
      S_MA2: begin
        cmd.dst = D_RD; cmd.wsrc = V_AD;
        ret_next = S_SA1; state_next = S_N0;
      end
      S_SA1: begin
        cmd.dst = D_AN; cmd.wsrc = V_RN; cmd.sgn = SG_A_R;
        state_next = S_SA2;
      end
      S_SA2: begin
        cmd.dst = D_AD; cmd.wsrc = V_RD;
        state_next = uses_b ? S_MB1 : S_OP;
      end
      S_MB1: begin
        cmd.dst = D_RN; cmd.wsrc = V_BN; cmd.sgn = SG_R_B;
        state_next = S_MB2;
      end
      S_MB2: begin
        cmd.dst = D_RD; cmd.wsrc = V_BD;
        ret_next = S_SB1; state_next = S_N0;
      end
      S_SB1: begin
        cmd.dst = D_BN; cmd.wsrc = V_RN; cmd.sgn = SG_B_R;
        state_next = S_SB2;
      end
      S_SB2: begin
        cmd.dst = D_BD; cmd.wsrc = V_RD;
        state_next = S_OP;
      end
      S_OP: begin
        case (op) inside
          CMD_ADD:                            state_next = S_AD1;
          CMD_MUL, CMD_DIV, CMD_EQ, CMD_LESS: state_next = S_ML1;
          CMD_WHOLE:                          state_next = S_EX1;
          default:                            state_next = S_FIN;
        endcase
      end
      // Reduce rn/rd by their gcd (a zero rn gives 0/1, positive), then return.
      S_N0: begin
        if (stat.rn_zero) begin
          cmd.dst = D_RD; cmd.wsrc = V_ONE; cmd.sgn = SG_R_CLR;
          state_next = ret;
        end else begin
          cmd.gcd_start = 1'b1; cmd.opa = V_RN; cmd.opb = V_RD;
          state_next = S_N1;
        end
      end
      S_N1: begin
        if (!stat.gcd_busy) begin
          cmd.div_start = 1'b1; cmd.opa = V_RN; cmd.opb = V_GCD;
          state_next = S_N2;
        end
      end
      S_N2: begin
        if (!stat.div_busy) begin
          cmd.dst = D_RN; cmd.wsrc = V_QUO;
          cmd.div_start = 1'b1; cmd.opa = V_RD; cmd.opb = V_GCD;
          state_next = S_N3;
        end
      end
      S_N3: begin
        if (!stat.div_busy) begin
          cmd.dst = D_RD; cmd.wsrc = V_QUO;
          state_next = ret;
        end
      end
      S_AD1: begin
        cmd.gcd_start = 1'b1; cmd.opa = V_AD; cmd.opb = V_BD;
        state_next = S_AD2;
      end
      S_AD2: begin
        if (!stat.gcd_busy) begin
          cmd.div_start = 1'b1; cmd.opa = V_BD; cmd.opb = V_GCD;
          state_next = S_AD3;
        end
      end
      S_AD3: begin
        if (!stat.div_busy) begin
          cmd.dst = D_T1; cmd.wsrc = V_QUO;
          cmd.div_start = 1'b1; cmd.opa = V_AD; cmd.opb = V_GCD;
          state_next = S_AD4;
        end
      end
      S_AD4: begin
        if (!stat.div_busy) begin
          cmd.dst = D_T2; cmd.wsrc = V_QUO;
          state_next = S_AD5;
        end
      end
      S_AD5: begin
        cmd.mul_en = 1'b1; cmd.opa = V_AD; cmd.opb = V_T1;
        state_next = S_AD6;
      end
      S_AD6: begin
        cmd.dst = D_RD; cmd.wsrc = V_PROD;
        cmd.mul_en = 1'b1; cmd.opa = V_AN; cmd.opb = V_T1;
        state_next = S_AD7;
      end
      S_AD7: begin
        cmd.dst = D_T1; cmd.wsrc = V_PROD;
        cmd.mul_en = 1'b1; cmd.opa = V_BN; cmd.opb = V_T2;
        state_next = S_ML3;
      end
      S_ML1: begin
        cmd.mul_en = 1'b1; cmd.opa = V_AN;
        cmd.opb = (op == CMD_MUL) ? V_BN : V_BD;
        state_next = S_ML2;
      end
      S_ML2: begin
        cmd.dst = D_RN; cmd.wsrc = V_PROD;
        cmd.mul_en = 1'b1; cmd.opa = V_AD;
        cmd.opb = (op == CMD_MUL) ? V_BD : V_BN;
        state_next = S_ML3;
      end
      S_ML3: begin
        if (op == CMD_ADD) begin
          cmd.dst = D_RN; cmd.wsrc = V_SUM; cmd.sgn = SG_R_SUM;
        end else begin
          cmd.dst = D_RD; cmd.wsrc = V_PROD; cmd.sgn = SG_R_XOR;
        end
        ret_next   = S_FIN;
        state_next = is_cmp ? S_FIN : S_N0;
      end
      S_EX1: begin
        cmd.div_start = 1'b1; cmd.opa = V_AN; cmd.opb = V_AD;
        state_next = S_EX2;
      end
      S_EX2: begin
        if (!stat.div_busy) begin
          cmd.dst = D_RN; cmd.wsrc = V_REM; cmd.sgn = SG_R_A;
          state_next = S_EX3;
        end
      end
      S_EX3: begin
        cmd.dst = D_WM; cmd.wsrc = V_QUO; cmd.sgn = SG_W_A;
        state_next = S_EX4;
      end
      S_EX4: begin
        cmd.dst = D_RD; cmd.wsrc = V_AD;
        ret_next = S_FIN; state_next = S_N0;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.fin = 1'b1;
          if (err) begin
            cmd.kind = K_ERR;
          end else if (op == CMD_NONE) begin
            cmd.kind = K_ZERO;
          end else if (op == CMD_EQ) begin
            cmd.kind = K_EQ;
          end else if (op == CMD_LESS) begin
            cmd.kind = K_LESS;
          end else begin
            cmd.kind = K_VAL;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      op    <= CMD_NORM;
      err   <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      op    <= op_next;
      err   <= err_next;
    end
  end

`ifndef SYNTHESIS
  a_gcd_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.gcd_start |-> !stat.gcd_busy && !stat.div_busy)
    else $error("gcd started while a unit is busy");
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.gcd_busy && (!stat.div_busy || state == S_N2 ||
                                         state == S_AD3))
    else $error("division started while a unit is busy");
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> !stat.out_busy)
    else $error("result formed while the output register is held");
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_CHECK)
    else $error("accepted item did not start the check");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> in_ready && in_valid)
    else $error("operands loaded outside a transfer");
`endif

endmodule

@@ sv/rational_arith_unit.sv @@
// Channel  Direction  Signals                    Contents
// s        input      s_tvalid s_tready          operands of one item
//                     s_tdata[127:0] s_tuser[2:0]
// m        output     m_tvalid m_tready          one result per item
//                     m_tdata[95:0] m_tuser[1:0]
//
// An item with a zero denominator or an undefined opcode finishes soonest,
// and an add on large operands takes longest. Item time is set by the
// binary gcd unit, which does one step a cycle, and the restoring divider,
// which gives one quotient bit a cycle.
// Reset is synchronous and active high; it clears the controller and the
// output valid flag. A result may wait on m_tready while the next item is
// accepted; the item then waits for the output register before finishing.
module rational_arith_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // a_num [31:0], a_den [63:32], b_num [95:64], b_den [127:96]
  input  logic [rau_pkg::IN_DATA_W-1:0]  s_tdata,
  // cmd [2:0]
  input  logic [rau_pkg::CMD_W-1:0]      s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // res_num [31:0], res_den [62:32], whole_part [94:63], truth [95]
  output logic [rau_pkg::OUT_DATA_W-1:0] m_tdata,
  // status [1:0]
  output logic [rau_pkg::STATUS_W-1:0]   m_tuser
);
  import rau_pkg::*;

  // The controller sequences the operation; the datapath holds the operand
  // and result magnitudes with their signs, a 32 by 32 multiplier, the gcd
  // unit and the divider. Every operand is first reduced by its gcd, the
  // operation is carried out exactly on 64-bit magnitudes, and a value result
  // is reduced again before the overflow check forms the output transfer.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (s_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

  rau_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rau_pkg::*;

  typedef bit bool_t;

  // One operation request as it travels on the slave side.
  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [31:0]      a_num;
    logic [31:0]      a_den;
    logic [31:0]      b_num;
    logic [31:0]      b_den;
  } rat_op_t;

  // One answer as it is expected on the master side.
  typedef struct {
    logic [31:0]         res_num;
    logic [30:0]         res_den;
    logic [31:0]         whole_part;
    logic                truth;
    logic [STATUS_W-1:0] status;
  } rat_ans_t;

  localparam int N_RANDOM    = 830;
  localparam int CYCLE_LIMIT = 4000000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [CMD_W-1:0]      s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  rat_op_t  pending_ops[$];
  rat_ans_t awaited_answers[$];
  int       error_count;
  int       answers_seen;
  int       cycle_count;
  bool_t    stimulus_done;
  bool_t    in_taken;
  int       send_gap;
  int       stall_left;
  int       cmd_hits[8];

  rational_arith_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Euclid on magnitudes; both arguments fit well within 64 bits.
  function automatic logic [63:0] gcd_of(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Splits a 32-bit two's complement word into sign and magnitude.
  function automatic void to_sign_mag(input logic [31:0] w, output bit neg,
                                      output logic [63:0] mag);
    neg = w[31];
    mag = neg ? (64'h1_0000_0000 - {32'd0, w}) : {32'd0, w};
  endfunction

  // Reduces num/den by their gcd; a zero numerator becomes 0/1 and positive.
  function automatic void reduce(inout bit neg, inout logic [63:0] num,
                                 inout logic [63:0] den);
    logic [63:0] g;
    if (num == 0) begin
      neg = 1'b0;
      den = 64'd1;
    end else begin
      g   = gcd_of(num, den);
      num = num / g;
      den = den / g;
    end
  endfunction

  function automatic bit in_word(input bit neg, input logic [63:0] mag);
    logic [63:0] lim;
    lim = (64'd1 << (WORD_BITS - 1)) - 64'd1;
    return neg ? (mag <= lim + 64'd1) : (mag <= lim);
  endfunction

  // Works out the answer the unit must give for one request.
  function automatic rat_ans_t rational_answer(input rat_op_t op);
    rat_ans_t    ans;
    bit          an, bn, rn, wn, dsg, ln, rgt;
    logic [63:0] am, ad, bm, bd, rm, rd, wm, common, lm, rmm;
    bit          uses_b;
    ans    = '{default: '0};
    uses_b = (op.cmd >= CMD_ADD) && (op.cmd <= CMD_LESS);
    if (op.cmd == CMD_NONE) return ans;
    if (op.a_den == 0 || (uses_b && op.b_den == 0) ||
        (op.cmd == CMD_DIV && op.b_num == 0)) begin
      ans.status = ST_ZERO_DEN;
      return ans;
    end
    to_sign_mag(op.a_num, an, am);
    to_sign_mag(op.a_den, dsg, ad);
    an = an ^ dsg;
    reduce(an, am, ad);
    bn = an; bm = am; bd = ad;
    if (uses_b) begin
      to_sign_mag(op.b_num, bn, bm);
      to_sign_mag(op.b_den, dsg, bd);
      bn = bn ^ dsg;
      reduce(bn, bm, bd);
    end
    rn = an; rm = am; rd = ad; wn = 1'b0; wm = 0;
    case (op.cmd)
      CMD_ADD: begin
        common = ad / gcd_of(ad, bd) * bd;
        lm  = am * (common / ad);
        rmm = bm * (common / bd);
        if (an == bn) begin
          rn = an; rm = lm + rmm;
        end else if (lm >= rmm) begin
          rn = an; rm = lm - rmm;
        end else begin
          rn = bn; rm = rmm - lm;
        end
        rd = common;
      end
      CMD_MUL: begin
        rn = an ^ bn; rm = am * bm; rd = ad * bd;
      end
      CMD_DIV: begin
        rn = an ^ bn; rm = am * bd; rd = ad * bm;
      end
      CMD_EQ, CMD_LESS: begin
        lm  = am * bd;
        rmm = ad * bm;
        ln  = (lm == 0) ? 1'b0 : an;
        rgt = (rmm == 0) ? 1'b0 : bn;
        if (op.cmd == CMD_EQ)
          ans.truth = (ln == rgt) && (lm == rmm);
        else if (ln != rgt)
          ans.truth = ln;
        else
          ans.truth = ln ? (lm > rmm) : (lm < rmm);
        return ans;
      end
      CMD_WHOLE: begin
        wn = an; wm = am / ad; rm = am % ad;
      end
      default: ;
    endcase
    reduce(rn, rm, rd);
    if (wm == 0) wn = 1'b0;
    if (!in_word(rn, rm) || !in_word(1'b0, rd) || !in_word(wn, wm)) begin
      ans.status = ST_OVERFLOW;
      return ans;
    end
    ans.res_num    = rn ? -rm[31:0] : rm[31:0];
    ans.res_den    = rd[30:0];
    ans.whole_part = wn ? -wm[31:0] : wm[31:0];
    return ans;
  endfunction

  // Operand values: mostly small so gcds and overflow both matter, with
  // extremes and full-range words mixed in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom();
      4:       return $urandom_range(65535) * (($urandom_range(1) != 0) ? -1 : 1);
      5:       return 32'd0;
      default: return $signed($urandom_range(40)) - 32'sd20;
    endcase
  endfunction

  function automatic logic [31:0] pick_den();
    logic [31:0] d;
    d = pick_word();
    // Zero denominators only occasionally so most items reach the arithmetic.
    if (d == 0 && $urandom_range(3) != 0) d = 32'd1;
    return d;
  endfunction

  task automatic add_op(input logic [CMD_W-1:0] c, input logic [31:0] an,
                        input logic [31:0] ad, input logic [31:0] bn,
                        input logic [31:0] bd);
    rat_op_t op;
    op.cmd = c; op.a_num = an; op.a_den = ad; op.b_num = bn; op.b_den = bd;
    pending_ops.push_back(op);
  endtask

  // Random gap length: often none, mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(3);
    return $urandom_range(60, 10);
  endfunction

  initial begin
    rat_op_t op;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    m_tready      = 1'b0;
    rst           = 1'b1;
    error_count   = 0;
    answers_seen  = 0;
    stimulus_done = 1'b0;

    // Directed part: every operation, the extreme words, and the special cases.
    add_op(CMD_NORM,  32'd6, -32'sd4, 32'd0, 32'd0);          // unused b may be 0/0
    add_op(CMD_NORM,  32'd0, -32'sd7, 32'd3, 32'd5);          // zero numerator gives 0/1
    add_op(CMD_NORM,  32'h8000_0000, 32'hFFFF_FFFF, 0, 1);    // magnitude 2^31 overflows
    add_op(CMD_NORM,  32'h8000_0000, 32'd1, 0, 1);
    add_op(CMD_NORM,  32'd5, 32'h8000_0000, 0, 1);            // denominator 2^31
    add_op(CMD_NORM,  32'd5, 32'd0, 1, 1);                    // zero denominator
    add_op(CMD_ADD,   32'd1, 32'd6, 32'd1, 32'd10);
    add_op(CMD_ADD,   32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
    add_op(CMD_ADD,   32'd1, 32'd3, 32'd1, 32'd0);            // b denominator zero
    add_op(CMD_ADD,   32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    add_op(CMD_MUL,   -32'sd3, 32'd4, 32'd8, -32'sd9);
    add_op(CMD_MUL,   32'h7FFF_FFFF, 32'd1, 32'd2, 32'd1);
    add_op(CMD_DIV,   32'd3, 32'd4, 32'd0, 32'd5);            // divide by zero value
    add_op(CMD_DIV,   32'd3, 32'd4, -32'sd9, 32'd2);
    add_op(CMD_DIV,   32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    add_op(CMD_EQ,    32'd2, 32'd4, -32'sd3, -32'sd6);
    add_op(CMD_EQ,    32'd0, 32'd5, 32'd0, -32'sd3);
    add_op(CMD_LESS,  -32'sd1, 32'd2, 32'd1, 32'd3);
    add_op(CMD_LESS,  32'd1, 32'd2, 32'd1, 32'd2);
    add_op(CMD_LESS,  32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_op(CMD_WHOLE, -32'sd7, 32'd2, 32'd0, 32'd0);
    add_op(CMD_WHOLE, 32'h8000_0000, 32'd1, 0, 0);            // whole part -2^31 still fits
    add_op(CMD_WHOLE, 32'd3, 32'd3, 0, 0);
    add_op(CMD_NONE,  32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);

    for (int i = 0; i < N_RANDOM; i++) begin
      op.cmd   = ($urandom_range(29) == 0) ? CMD_NONE : CMD_W'($urandom_range(6));
      op.a_num = pick_word();
      op.a_den = pick_den();
      op.b_num = pick_word();
      op.b_den = pick_den();
      pending_ops.push_back(op);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Notes whether the request on the slave side went across at this edge.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
    end
  end

  // Slave-side driver: presents the next request after a random gap and
  // holds it until the transfer happens.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (s_tvalid && !in_taken) begin
      // Request still waiting; keep it as it is.
    end else if (send_gap > 0) begin
      s_tvalid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_ops.size() > 0) begin
      rat_op_t op;
      op = pending_ops.pop_front();
      s_tvalid <= 1'b1;
      s_tuser  <= op.cmd;
      s_tdata  <= {op.b_den, op.b_num, op.a_den, op.a_num};
      awaited_answers.push_back(rational_answer(op));
      cmd_hits[op.cmd] = cmd_hits[op.cmd] + 1;
      send_gap <= pick_gap();
    end else begin
      s_tvalid      <= 1'b0;
      stimulus_done <= 1'b1;
    end
  end

  // Master-side back pressure: ready is dropped for random stretches.
  always @(negedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready   <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Monitor: each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      rat_ans_t want;
      answers_seen <= answers_seen + 1;
      if (awaited_answers.size() == 0) begin
        $error("result with nothing expected: tdata %h tuser %0d", m_tdata, m_tuser);
        error_count = error_count + 1;
      end else begin
        want = awaited_answers.pop_front();
        if (m_tdata[31:0] !== want.res_num) begin
          $error("res_num expected %h actual %h", want.res_num, m_tdata[31:0]);
          error_count = error_count + 1;
        end
        if (m_tdata[62:32] !== want.res_den) begin
          $error("res_den expected %h actual %h", want.res_den, m_tdata[62:32]);
          error_count = error_count + 1;
        end
        if (m_tdata[94:63] !== want.whole_part) begin
          $error("whole_part expected %h actual %h", want.whole_part, m_tdata[94:63]);
          error_count = error_count + 1;
        end
        if (m_tdata[95] !== want.truth) begin
          $error("truth expected %b actual %b", want.truth, m_tdata[95]);
          error_count = error_count + 1;
        end
        if (m_tuser !== want.status) begin
          $error("status expected %0d actual %0d", want.status, m_tuser);
          error_count = error_count + 1;
        end
      end
    end
  end

  // Run control: a hard cycle limit, and the final verdict once everything
  // has been sent and every expected result has come back.
  initial begin
    cycle_count = 0;
    @(negedge rst);
    while (!(stimulus_done && awaited_answers.size() == 0) && cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding", awaited_answers.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      // Allow a stray extra result to surface before the verdict.
      repeat (2000) @(posedge clk);
      $display("Checked %0d results in %0d cycles: norm %0d add %0d mul %0d div %0d",
               answers_seen, cycle_count, cmd_hits[0], cmd_hits[1], cmd_hits[2],
               cmd_hits[3]);
      $display("eq %0d less %0d whole %0d undefined %0d, with random stalls on both sides",
               cmd_hits[4], cmd_hits[5], cmd_hits[6], cmd_hits[7]);
      if (error_count == 0) begin
        $display("Regression PASS");
      end else begin
        $display("Regression FAIL");
      end
      $finish;
    end
  end

endmodule
